>>> rtl/ilt_pkg.sv
// ---------------------------------------------------------------------------
// ilt_pkg
// Types, constants and character classes for the IRC line tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

    localparam int unsigned MAX_PARAMS = 15;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;

    localparam logic [1:0] NUM_DIGITS = 2'd3;

    localparam logic [2:0] K_DELIM = 3'd0;
    localparam logic [2:0] K_NAME  = 3'd1;
    localparam logic [2:0] K_USER  = 3'd2;
    localparam logic [2:0] K_HOST  = 3'd3;
    localparam logic [2:0] K_CMD   = 3'd4;
    localparam logic [2:0] K_MID   = 3'd5;
    localparam logic [2:0] K_TRAIL = 3'd6;
    localparam logic [2:0] K_DISC  = 3'd7;

    typedef enum logic [3:0] {
        PH_START,
        PH_NAME_FIRST,
        PH_NAME_HOST,
        PH_NAME_NICK,
        PH_USER_FIRST,
        PH_USER,
        PH_HOST_FIRST,
        PH_HOST,
        PH_PFX_SPACE,
        PH_CMD_ALPHA,
        PH_CMD_NUM,
        PH_PAR_SPACE,
        PH_MIDDLE,
        PH_TRAIL_FIRST,
        PH_TRAIL,
        PH_CR
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] param_count;
        logic [1:0] digit_count;
        logic       nick_valid;
        logic       numeric;
        logic       error;
    } state_t;

    typedef struct packed {
        logic [7:0] byte_echo;
        logic [2:0] field_kind;
        logic       field_first;
        logic [3:0] param_index;
        logic       line_end;
        logic       line_ok;
        logic       parse_error;
        logic       name_is_nick;
        logic       command_numeric;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase: PH_START, param_count: 4'd0, digit_count: 2'd0,
        nick_valid: 1'b0, numeric: 1'b0, error: 1'b0
    };

    function automatic logic c_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic c_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic c_alpha(input logic [7:0] c);
        return c_letter(c) || ((c >= 8'h5B) && (c <= 8'h5E)) ||
               ((c >= 8'h7B) && (c <= 8'h7E));
    endfunction

    function automatic logic c_nick(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h7D)) || c_digit(c) || (c == 8'h2D);
    endfunction

    function automatic logic c_user(input logic [7:0] c);
        return c_nick(c) || (c == 8'h2E) || (c == 8'h7E);
    endfunction

    function automatic logic c_host(input logic [7:0] c);
        return ((c >= 8'h2D) && (c <= 8'h3A)) || c_letter(c);
    endfunction

    function automatic logic c_lineend(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

>>> rtl/ilt_step.sv
// ---------------------------------------------------------------------------
// ilt_step
// Per-byte parse step: classifies one byte against the current line state
// and returns the tagged result and the following state.
// ---------------------------------------------------------------------------
`default_nettype none

module ilt_step (
    input  wire logic [7:0]      data_byte,
    input  wire ilt_pkg::state_t cur,
    output ilt_pkg::state_t      next,
    output ilt_pkg::result_t     res
);
    import ilt_pkg::*;

    state_t     nxt;
    logic [2:0] kind;
    logic       first;
    logic       err;
    logic       lend;
    logic       lok;
    logic       cmd_done;
    logic       name_h;
    logic       name_n;
    logic       cmd_alpha;
    logic       cmd_digit;

    assign cmd_alpha = c_alpha(data_byte);
    assign cmd_digit = c_digit(data_byte);
    assign cmd_done  = (cur.phase == PH_CMD_ALPHA) || (cur.digit_count == NUM_DIGITS);
    assign name_h    = (cur.phase == PH_NAME_HOST) && c_host(data_byte);
    assign name_n    = cur.nick_valid && c_nick(data_byte);

    always_comb begin
        nxt   = cur;
        kind  = K_DELIM;
        first = 1'b0;
        err   = 1'b0;
        lend  = 1'b0;
        lok   = 1'b0;
        if (data_byte == CH_LF) begin
            lend = 1'b1;
            if (!cur.error) begin
                if (cur.phase == PH_CR) begin
                    lok = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
        end else if (cur.error) begin
            kind = K_DISC;
        end else begin
            case (cur.phase)
                PH_START, PH_PFX_SPACE: begin
                    if ((cur.phase == PH_START) && (data_byte == CH_COLON)) begin
                        nxt.phase = PH_NAME_FIRST;
                    end else if ((cur.phase == PH_START) && (data_byte == CH_CR)) begin
                        nxt.phase = PH_CR;
                    end else if ((cur.phase == PH_PFX_SPACE) && (data_byte == CH_SPACE)) begin
                        nxt.phase = PH_PFX_SPACE;
                    end else if (cmd_alpha) begin
                        nxt.phase = PH_CMD_ALPHA;
                        kind      = K_CMD;
                        first     = 1'b1;
                    end else if (cmd_digit) begin
                        nxt.phase       = PH_CMD_NUM;
                        nxt.digit_count = 2'd1;
                        nxt.numeric     = 1'b1;
                        kind            = K_CMD;
                        first           = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_NAME_FIRST: begin
                    if (c_host(data_byte) || cmd_alpha) begin
                        nxt.nick_valid = cmd_alpha;
                        nxt.phase      = c_host(data_byte) ? PH_NAME_HOST : PH_NAME_NICK;
                        kind           = K_NAME;
                        first          = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_NAME_HOST, PH_NAME_NICK: begin
                    if (data_byte == CH_SPACE) begin
                        nxt.phase = PH_PFX_SPACE;
                    end else if (data_byte == CH_BANG) begin
                        nxt.phase = PH_USER_FIRST;
                    end else if (data_byte == CH_AT) begin
                        nxt.phase = PH_HOST_FIRST;
                    end else if (!name_h && !name_n) begin
                        err = 1'b1;
                    end else begin
                        nxt.phase      = name_h ? PH_NAME_HOST : PH_NAME_NICK;
                        nxt.nick_valid = name_n;
                        kind           = K_NAME;
                    end
                end
                PH_USER_FIRST, PH_USER: begin
                    if ((cur.phase == PH_USER) && (data_byte == CH_SPACE)) begin
                        nxt.phase = PH_PFX_SPACE;
                    end else if ((cur.phase == PH_USER) && (data_byte == CH_AT)) begin
                        nxt.phase = PH_HOST_FIRST;
                    end else if (c_user(data_byte)) begin
                        first     = (cur.phase == PH_USER_FIRST);
                        nxt.phase = PH_USER;
                        kind      = K_USER;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_HOST_FIRST, PH_HOST: begin
                    if ((cur.phase == PH_HOST) && (data_byte == CH_SPACE)) begin
                        nxt.phase = PH_PFX_SPACE;
                    end else if (c_host(data_byte)) begin
                        first     = (cur.phase == PH_HOST_FIRST);
                        nxt.phase = PH_HOST;
                        kind      = K_HOST;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_CMD_ALPHA, PH_CMD_NUM: begin
                    if ((data_byte == CH_SPACE) && cmd_done) begin
                        nxt.phase = PH_PAR_SPACE;
                    end else if ((data_byte == CH_CR) && cmd_done) begin
                        nxt.phase = PH_CR;
                    end else if ((cur.phase == PH_CMD_ALPHA) && cmd_alpha) begin
                        kind = K_CMD;
                    end else if ((cur.phase == PH_CMD_NUM) && cmd_digit &&
                                 (cur.digit_count < NUM_DIGITS)) begin
                        nxt.digit_count = cur.digit_count + 2'd1;
                        kind            = K_CMD;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_PAR_SPACE: begin
                    if (data_byte == CH_SPACE) begin
                        nxt.phase = PH_PAR_SPACE;
                    end else if (data_byte == CH_COLON) begin
                        nxt.phase = PH_TRAIL_FIRST;
                    end else if (c_lineend(data_byte)) begin
                        err = 1'b1;
                    end else begin
                        nxt.phase = PH_MIDDLE;
                        kind      = K_MID;
                        first     = 1'b1;
                    end
                end
                PH_MIDDLE: begin
                    if (data_byte == CH_SPACE) begin
                        if (cur.param_count < 4'(MAX_PARAMS)) begin
                            nxt.param_count = cur.param_count + 4'd1;
                        end
                        nxt.phase = PH_PAR_SPACE;
                    end else if (data_byte == CH_CR) begin
                        nxt.phase = PH_CR;
                    end else if (data_byte == CH_NUL) begin
                        err = 1'b1;
                    end else begin
                        kind = K_MID;
                    end
                end
                PH_TRAIL_FIRST, PH_TRAIL: begin
                    if ((cur.phase == PH_TRAIL) && (data_byte == CH_CR)) begin
                        nxt.phase = PH_CR;
                    end else if (c_lineend(data_byte)) begin
                        err = 1'b1;
                    end else begin
                        first     = (cur.phase == PH_TRAIL_FIRST);
                        nxt.phase = PH_TRAIL;
                        kind      = K_TRAIL;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end

        if (err) begin
            first = 1'b0;
            if (data_byte != CH_LF) begin
                kind      = K_DISC;
                nxt.error = 1'b1;
            end
        end
    end

    assign res.byte_echo       = data_byte;
    assign res.field_kind      = kind;
    assign res.field_first     = first;
    assign res.param_index     = nxt.param_count;
    assign res.line_end        = lend;
    assign res.line_ok         = lok;
    assign res.parse_error     = err;
    assign res.name_is_nick    = nxt.nick_valid;
    assign res.command_numeric = nxt.numeric;

    assign next = lend ? STATE_RESET : nxt;

endmodule

`default_nettype wire

>>> rtl/irc_line_tokenizer.sv
// ---------------------------------------------------------------------------
// irc_line_tokenizer
// Tags each byte of an IRC stream with its message field, one byte a cycle.
// ---------------------------------------------------------------------------
// Input channel s_*: one raw stream byte per transfer in s_tdata.
// Output channel m_*: one tagged byte per input byte. m_tuser carries the
// field kind, m_tlast marks the LF that closes a line, m_tdata holds the
// byte and its flags.
// The parse step sits between the line state register and the output
// register, so a byte accepted at one edge is offered on m_* after it.
// Throughput is one byte per cycle while the receiver keeps up; the line
// state loop through the parse step is what sets that figure.
// s_tready is high while the output register is empty or being drained, so
// a stalled receiver holds the pending result and stops further input
// after one byte.
// Reset (aresetn low, synchronous) empties the output register and returns
// the parser to the start of a line with all flags clear.
// ---------------------------------------------------------------------------
`default_nettype none

module irc_line_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // byte_echo, field_first, param_index,
                                        // line_ok, parse_error, name_is_nick,
                                        // command_numeric, zero fill
    output logic [2:0]       m_tuser,   // field_kind
    output logic             m_tlast    // line_end
);
    import ilt_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t res_reg;
    logic    m_tvalid_reg;
    logic    s_xfer;

    ilt_step u_step (
        .data_byte (s_tdata),
        .cur       (state_reg),
        .next      (state_next),
        .res       (step_res)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                state_reg <= state_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.field_kind;
    assign m_tlast  = res_reg.line_end;
    assign m_tdata  = {7'd0,
                       res_reg.command_numeric,
                       res_reg.name_is_nick,
                       res_reg.parse_error,
                       res_reg.line_ok,
                       res_reg.param_index,
                       res_reg.field_first,
                       res_reg.byte_echo};

`ifndef SYNTH
    a_lf_restarts_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (s_tdata == CH_LF)) |=>
            ((state_reg.phase == PH_START) && (state_reg.param_count == 4'd0) &&
             !state_reg.error))
        else $error("line state not cleared after LF");

    a_ok_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.line_ok) |-> (m_tlast && !res_reg.parse_error))
        else $error("line_ok outside a clean line end");

    a_error_not_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.parse_error) |-> !res_reg.field_first)
        else $error("erroneous byte marked as field start");

    a_error_discards: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && state_reg.error && (s_tdata != CH_LF)) |=>
            (state_reg.error && (res_reg.field_kind == K_DISC) && !res_reg.parse_error))
        else $error("byte after error not discarded");
`endif

endmodule

`default_nettype wire
